FILE: rtl/core/bsa_pkg.sv
// Shared types, codes and widths for the bitmap slot allocator.
`default_nettype none
package bsa_pkg;

	localparam int MAP_W      = 64;
	localparam int IDX_W      = $clog2(MAP_W);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 32;
	localparam int BYTES_W    = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int MUL_CNT_W  = $clog2(IDX_W);
	localparam int DIV_CNT_W  = $clog2(ADDR_W);

	typedef enum logic [1:0] {
		STATUS_DONE         = 2'd0,
		STATUS_TOO_LARGE    = 2'd1,
		STATUS_NO_SLOT      = 2'd2,
		STATUS_FREE_IGNORED = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOT_BYTES  = 2'd0,
		CFG_SLOT_COUNT  = 2'd1,
		CFG_REGION_BASE = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] idx;
	} scan_res_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] addr;
	} mul_res_t;

	typedef struct packed {
		logic             done;
		logic             over;
		logic [IDX_W-1:0] idx;
	} div_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/bsa_scan.sv
// Bit-serial search for the lowest free slot below the slot count.
`default_nettype none
module bsa_scan (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bsa_pkg::MAP_W-1:0]  map,
	input  wire logic [bsa_pkg::CNT_W-1:0]  count,
	output bsa_pkg::scan_res_t              res
);

	logic                       busy_q;
	logic [bsa_pkg::MAP_W-1:0]  sr_q;
	logic [bsa_pkg::CNT_W-1:0]  cnt_q;
	logic                       past_end;
	logic                       hit;

	// past_end covers both the slot count and the full map width
	assign past_end = cnt_q[bsa_pkg::CNT_W-1] || (cnt_q >= count);
	assign hit      = !past_end && !sr_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (past_end || hit)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q  <= map;
			cnt_q <= '0;
		end else if (busy_q && !(past_end || hit)) begin
			sr_q  <= {1'b1, sr_q[bsa_pkg::MAP_W-1:1]};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign res.done  = busy_q && (past_end || hit);
	assign res.found = hit;
	assign res.idx   = cnt_q[bsa_pkg::IDX_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/bsa_mul.sv
// Shift-add slot address: base + index * slot size, one index bit per cycle.
`default_nettype none
module bsa_mul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bsa_pkg::IDX_W-1:0]    idx,
	input  wire logic [bsa_pkg::BYTES_W-1:0]  slot_bytes,
	input  wire logic [bsa_pkg::ADDR_W-1:0]   base,
	output bsa_pkg::mul_res_t                 res
);

	logic                             busy_q;
	logic                             done_q;
	logic [bsa_pkg::MUL_CNT_W-1:0]    cnt_q;
	logic [bsa_pkg::IDX_W-1:0]        idx_sr_q;
	logic [bsa_pkg::ADDR_W-1:0]       mcand_q;
	logic [bsa_pkg::ADDR_W-1:0]       acc_q;
	logic                             last;

	assign last = (cnt_q == bsa_pkg::MUL_CNT_W'(bsa_pkg::IDX_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q    <= '0;
			idx_sr_q <= idx;
			mcand_q  <= {{(bsa_pkg::ADDR_W - bsa_pkg::BYTES_W){1'b0}}, slot_bytes};
			acc_q    <= base;
		end else if (busy_q) begin
			cnt_q    <= cnt_q + 1'b1;
			idx_sr_q <= idx_sr_q >> 1;
			mcand_q  <= mcand_q << 1;
			if (idx_sr_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.addr = acc_q;

endmodule
`default_nettype wire

FILE: rtl/core/bsa_div.sv
// Restoring divider turning a region offset into a slot index, one quotient bit per cycle.
`default_nettype none
module bsa_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bsa_pkg::ADDR_W-1:0]   dividend,
	input  wire logic [bsa_pkg::BYTES_W-1:0]  divisor,
	output bsa_pkg::div_res_t                 res
);

	logic                             busy_q;
	logic                             done_q;
	logic [bsa_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [bsa_pkg::ADDR_W-1:0]       dvd_q;
	logic [bsa_pkg::BYTES_W-1:0]      dsr_q;
	logic [bsa_pkg::BYTES_W-1:0]      rem_q;
	logic [bsa_pkg::BYTES_W:0]        trial;
	logic [bsa_pkg::BYTES_W:0]        diff;
	logic                             ge;
	logic                             last;

	assign trial = {rem_q, dvd_q[bsa_pkg::ADDR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign last  = (cnt_q == bsa_pkg::DIV_CNT_W'(bsa_pkg::ADDR_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient bits shift into the bottom of the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			dvd_q <= {dvd_q[bsa_pkg::ADDR_W-2:0], ge};
			rem_q <= ge ? diff[bsa_pkg::BYTES_W-1:0] : trial[bsa_pkg::BYTES_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.over = |dvd_q[bsa_pkg::ADDR_W-1:bsa_pkg::IDX_W];
	assign res.idx  = dvd_q[bsa_pkg::IDX_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: occupancy map, sequencer and result register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | req_type, request_size, release_address
//  out      | out_valid / out_stall | status, slot_index, slot_address, granted_bytes
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time.
// Allocate: decode, then the map scan up to the granted index (the map scan steps one slot per
// cycle), then the six shift-add address steps. No free slot: the scan ends at the slot count or map end.
// Free: the 32-step restoring divider. A failed size or base check, or a zero slot size, goes to the result.
// Reset clears the map, configuration, state and valid flags at once; result data is not reset.
// A stalled result sits in the output register while the next request is taken in.
`default_nettype none
module bitmap_slot_allocator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bsa_pkg::ADDR_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             req_type,
	input  wire logic [bsa_pkg::SIZE_W-1:0]       request_size,
	input  wire logic [bsa_pkg::ADDR_W-1:0]       release_address,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [1:0]                            status,
	output logic [bsa_pkg::IDX_W-1:0]             slot_index,
	output logic [bsa_pkg::ADDR_W-1:0]            slot_address,
	output logic [bsa_pkg::BYTES_W-1:0]           granted_bytes
);

	bsa_pkg::state_t                  state_q, state_nxt;
	logic [bsa_pkg::BYTES_W-1:0]      slot_bytes_q;
	logic [bsa_pkg::CNT_W-1:0]        slot_count_q;
	logic [bsa_pkg::ADDR_W-1:0]       region_base_q;
	logic [bsa_pkg::MAP_W-1:0]        occ_q;

	bsa_pkg::req_t                    req_type_q;
	logic [bsa_pkg::SIZE_W-1:0]       size_q;
	logic [bsa_pkg::ADDR_W-1:0]       rel_q;

	bsa_pkg::status_t                 res_status_q;
	logic [bsa_pkg::IDX_W-1:0]        res_idx_q;
	logic [bsa_pkg::ADDR_W-1:0]       res_addr_q;
	logic [bsa_pkg::BYTES_W-1:0]      res_bytes_q;

	bsa_pkg::status_t                 status_q;
	logic [bsa_pkg::IDX_W-1:0]        slot_index_q;
	logic [bsa_pkg::ADDR_W-1:0]       slot_address_q;
	logic [bsa_pkg::BYTES_W-1:0]      granted_bytes_q;
	logic                             out_valid_q;

	logic                             scan_start, mul_start, div_start;
	logic                             in_take, out_load;
	logic                             too_large;
	logic [bsa_pkg::ADDR_W:0]         rel_diff;
	logic                             free_bad;
	bsa_pkg::scan_res_t               scan_res;
	bsa_pkg::mul_res_t                mul_res;
	bsa_pkg::div_res_t                div_res;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != bsa_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == bsa_pkg::ST_FIN) && (!out_valid_q || !out_stall);

	assign too_large = (size_q > {{(bsa_pkg::SIZE_W - bsa_pkg::BYTES_W){1'b0}}, slot_bytes_q});
	assign rel_diff  = {1'b0, rel_q} - {1'b0, region_base_q};
	assign free_bad  = rel_diff[bsa_pkg::ADDR_W] || (slot_bytes_q == '0);

	bsa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.map    (occ_q),
		.count  (slot_count_q),
		.res    (scan_res)
	);

	bsa_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mul_start),
		.idx        (scan_res.idx),
		.slot_bytes (slot_bytes_q),
		.base       (region_base_q),
		.res        (mul_res)
	);

	bsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rel_diff[bsa_pkg::ADDR_W-1:0]),
		.divisor  (slot_bytes_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		scan_start = 1'b0;
		mul_start  = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			bsa_pkg::ST_IDLE: begin
				if (in_take) begin
					state_nxt = bsa_pkg::ST_DECODE;
				end
			end
			bsa_pkg::ST_DECODE: begin
				if (req_type_q == bsa_pkg::REQ_ALLOC) begin
					if (too_large) begin
						state_nxt = bsa_pkg::ST_FIN;
					end else begin
						scan_start = 1'b1;
						state_nxt  = bsa_pkg::ST_SCAN;
					end
				end else if (free_bad) begin
					state_nxt = bsa_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_nxt = bsa_pkg::ST_DIV;
				end
			end
			bsa_pkg::ST_SCAN: begin
				if (scan_res.done) begin
					if (scan_res.found) begin
						mul_start = 1'b1;
						state_nxt = bsa_pkg::ST_MUL;
					end else begin
						state_nxt = bsa_pkg::ST_FIN;
					end
				end
			end
			bsa_pkg::ST_MUL: begin
				if (mul_res.done) begin
					state_nxt = bsa_pkg::ST_FIN;
				end
			end
			bsa_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_nxt = bsa_pkg::ST_FIN;
				end
			end
			bsa_pkg::ST_FIN: begin
				if (out_load) begin
					state_nxt = bsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bsa_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration and occupancy map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q  <= '0;
			slot_count_q  <= '0;
			region_base_q <= '0;
			occ_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bsa_pkg::CFG_SLOT_BYTES:  slot_bytes_q  <= cfg_data[bsa_pkg::BYTES_W-1:0];
					bsa_pkg::CFG_SLOT_COUNT:  slot_count_q  <= cfg_data[bsa_pkg::CNT_W-1:0];
					bsa_pkg::CFG_REGION_BASE: region_base_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == bsa_pkg::ST_SCAN) && scan_res.done && scan_res.found) begin
				occ_q[scan_res.idx] <= 1'b1;
			end else if ((state_q == bsa_pkg::ST_DIV) && div_res.done && !div_res.over) begin
				occ_q[div_res.idx] <= 1'b0;
			end
		end
	end

	// request capture and working result
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_type_q <= bsa_pkg::req_t'(req_type);
			size_q     <= request_size;
			rel_q      <= release_address;
		end
		case (state_q)
			bsa_pkg::ST_DECODE: begin
				res_idx_q   <= '0;
				res_addr_q  <= '0;
				res_bytes_q <= '0;
				if (req_type_q == bsa_pkg::REQ_ALLOC) begin
					res_status_q <= bsa_pkg::STATUS_TOO_LARGE;
				end else begin
					res_status_q <= bsa_pkg::STATUS_FREE_IGNORED;
				end
			end
			bsa_pkg::ST_SCAN: begin
				if (scan_res.done) begin
					if (scan_res.found) begin
						res_status_q <= bsa_pkg::STATUS_DONE;
						res_idx_q    <= scan_res.idx;
					end else begin
						res_status_q <= bsa_pkg::STATUS_NO_SLOT;
					end
				end
			end
			bsa_pkg::ST_MUL: begin
				if (mul_res.done) begin
					res_addr_q  <= mul_res.addr;
					res_bytes_q <= slot_bytes_q;
				end
			end
			bsa_pkg::ST_DIV: begin
				if (div_res.done && !div_res.over) begin
					res_status_q <= bsa_pkg::STATUS_DONE;
					res_idx_q    <= div_res.idx;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q        <= res_status_q;
			slot_index_q    <= res_idx_q;
			slot_address_q  <= res_addr_q;
			granted_bytes_q <= res_bytes_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_index_q;
	assign slot_address  = slot_address_q;
	assign granted_bytes = granted_bytes_q;

	a_scan_free: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_res.done && scan_res.found) |-> !occ_q[scan_res.idx])
		else $error("scan granted an occupied slot");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_res.done && scan_res.found) |-> ({1'b0, scan_res.idx} < slot_count_q))
		else $error("scan granted a slot beyond the slot count");

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bsa_pkg::ST_SCAN) && scan_res.done && scan_res.found)
		|=> occ_q[$past(scan_res.idx)])
		else $error("granted slot not marked used");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_res.done |-> (state_q == bsa_pkg::ST_MUL))
		else $error("address unit finished outside its step");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == bsa_pkg::ST_DIV))
		else $error("divider finished outside its step");

endmodule
`default_nettype wire
